// File: sv/clock_offset_mad_tracker_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef CLOCK_OFFSET_MAD_TRACKER_UNIT_MACROS_SVH
`define CLOCK_OFFSET_MAD_TRACKER_UNIT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define COMT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define COMT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/comt_pkg.sv
package comt_pkg;

    localparam int RESID_W = 40;
    localparam int TIME_W  = 63;
    localparam int OFS_W   = 48;
    localparam int GAIN_W  = 17;
    localparam int WLEN_W  = 6;
    localparam int WARM_W  = 16;

    typedef logic [RESID_W-1:0] resid_t;
    typedef logic [TIME_W-1:0]  time_t;

    localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'd65536;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd6554;
    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 6'd32;
    localparam logic [WARM_W-1:0]  WARM_RESET  = 16'd30;
    localparam resid_t             LIMIT_RESET = 40'd1000000;
    localparam logic [WARM_W-1:0]  FRAMES_MAX  = 16'hFFFF;

    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_WLEN  = 2'd1;
    localparam logic [1:0] REG_WARM  = 2'd2;
    localparam logic [1:0] REG_LIMIT = 2'd3;

endpackage

// File: sv/comt_ram.sv
module comt_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/clock_offset_mad_tracker_unit.sv
// Clock offset tracker. Each input beat carries two host timestamps and one sensor timestamp;
// the block smooths the host-minus-sensor offset with an EWMA, keeps the rounded residuals in
// a ring RAM, and once the warmup count is reached takes the upper median of the window and
// then the median absolute deviation, setting is_ready when it is at or below the limit register. One
// beat returns one result beat. The offset update steps through the sum, magnitude, sample,
// difference, two partial-product, step and update states; the deviation check then sweeps the
// window once per candidate through the single ring RAM read port that serves both median
// searches. The input is not ready while a beat is being worked on.
module clock_offset_mad_tracker_unit import comt_pkg::*; #(
    parameter int WINDOW_MAX = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [TIME_W-1:0]   s_host_before_ns,
    input  logic [TIME_W-1:0]   s_host_after_ns,
    input  logic [TIME_W-1:0]   s_sensor_ns,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TIME_W-1:0]   m_host_time_ns,
    output logic signed [OFS_W-1:0] m_offset_int_ns,
    output logic                m_is_ready,
    output logic [RESID_W-1:0]  m_deviation_ns,
    output logic                m_deviation_valid
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SH = FRAC_BITS - 1;
    localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF >> SH;
    localparam logic [63:0] NEG_LIM = 64'd1 << (63 - SH);
    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SUM  = 4'd1;
    localparam logic [3:0] ST_MAG  = 4'd2;
    localparam logic [3:0] ST_SAMP = 4'd3;
    localparam logic [3:0] ST_DIFF = 4'd4;
    localparam logic [3:0] ST_MLO  = 4'd5;
    localparam logic [3:0] ST_MHI  = 4'd6;
    localparam logic [3:0] ST_STEP = 4'd7;
    localparam logic [3:0] ST_UPD  = 4'd8;
    localparam logic [3:0] ST_RES  = 4'd9;
    localparam logic [3:0] ST_WR   = 4'd10;
    localparam logic [3:0] ST_MAP  = 4'd11;
    localparam logic [3:0] ST_CRD  = 4'd12;
    localparam logic [3:0] ST_CLD  = 4'd13;
    localparam logic [3:0] ST_SWP  = 4'd14;
    localparam logic [3:0] ST_FIN  = 4'd15;

    logic [3:0]          state_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [WLEN_W-1:0]   wlen_reg;
    logic [WARM_W-1:0]   warm_reg;
    resid_t              limit_reg;
    time_t               hb_reg, ha_reg, sn_reg;
    logic [63:0]         sum_reg, mag_reg, sample_reg, offs_reg, diff_reg, step_reg;
    logic                neg_reg, dir_reg;
    logic [48:0]         prod_lo_reg, prod_hi_reg;
    logic [AW-1:0]       head_reg;
    logic [CW-1:0]       fill_reg, n_reg, i_reg, j_reg, lt_reg, le_reg;
    logic [WARM_W-1:0]   frames_reg;
    logic                flag_reg, pass_reg;
    resid_t              cand_reg, med_reg, dev_reg;
    logic                dval_reg;
    time_t               host_reg;
    logic [OFS_W-1:0]    ofs_reg;
    logic                m_valid_reg;
    time_t               out_host_reg;
    logic [OFS_W-1:0]    out_ofs_reg;
    logic                out_ready_reg, out_dval_reg;
    resid_t              out_dev_reg;

    logic [GAIN_W-1:0]   gain_eff;
    logic [63:0]         res_full;
    resid_t              res_sat;
    logic [63:0]         oi;
    logic signed [64:0]  host_sum;
    logic [15:0]         wl_eff;
    logic [CW-1:0]       n_next, k_val, lt_next, le_next, j_inc;
    resid_t              rdata, rd_val, sweep_val;
    logic [AW-1:0]       raddr;
    logic                cfg_wr;

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] hd, input logic [CW-1:0] x);
        logic [AW+1:0] t;
        t = (AW+2)'(hd) + (AW+2)'(WINDOW_MAX - 1) - (AW+2)'(x);
        if (t >= (AW+2)'(WINDOW_MAX)) begin
            t = t - (AW+2)'(WINDOW_MAX);
        end
        return t[AW-1:0];
    endfunction

    function automatic resid_t abs_diff(input resid_t a, input resid_t m);
        return (a >= m) ? a - m : m - a;
    endfunction

    comt_ram #(.WIDTH(RESID_W), .DEPTH(WINDOW_MAX)) u_ring (
        .aclk  (aclk),
        .we    (state_reg == ST_WR),
        .waddr (head_reg),
        .wdata (res_sat),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    assign m_valid           = m_valid_reg;
    assign m_host_time_ns    = out_host_reg;
    assign m_offset_int_ns   = out_ofs_reg;
    assign m_is_ready        = out_ready_reg;
    assign m_deviation_ns    = out_dev_reg;
    assign m_deviation_valid = out_dval_reg;

    always_comb begin
        case (paddr[4:3])
            REG_GAIN:  prdata = 64'(gain_reg);
            REG_WLEN:  prdata = 64'(wlen_reg);
            REG_WARM:  prdata = 64'(warm_reg);
            REG_LIMIT: prdata = 64'(limit_reg);
            default:   prdata = 64'd0;
        endcase
    end

    always_comb begin
        gain_eff = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
        res_full = (diff_reg >> FRAC_BITS) + 64'(diff_reg[FRAC_BITS-1]);
        res_sat  = (res_full > 64'(40'hFF_FFFF_FFFF)) ? 40'hFF_FFFF_FFFF : res_full[RESID_W-1:0];
        oi       = 64'($signed(offs_reg) >>> FRAC_BITS);
        host_sum = $signed({2'b00, sn_reg}) + $signed({oi[63], oi});
        if (wlen_reg == '0) begin
            wl_eff = 16'd1;
        end else if (16'(wlen_reg) > 16'(WINDOW_MAX)) begin
            wl_eff = 16'(WINDOW_MAX);
        end else begin
            wl_eff = 16'(wlen_reg);
        end
        n_next    = (16'(fill_reg) < wl_eff) ? fill_reg : wl_eff[CW-1:0];
        k_val     = n_reg >> 1;
        rd_val    = pass_reg ? abs_diff(rdata, med_reg) : rdata;
        sweep_val = rd_val;
        lt_next   = lt_reg + CW'(sweep_val < cand_reg);
        le_next   = le_reg + CW'(sweep_val <= cand_reg);
        j_inc     = j_reg + CW'(1);
        case (state_reg)
            ST_CRD:  raddr = ring_addr(head_reg, i_reg);
            ST_CLD:  raddr = ring_addr(head_reg, '0);
            default: raddr = ring_addr(head_reg, j_inc);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gain_reg    <= GAIN_RESET;
            wlen_reg    <= WLEN_RESET;
            warm_reg    <= WARM_RESET;
            limit_reg   <= LIMIT_RESET;
            offs_reg    <= '0;
            head_reg    <= '0;
            fill_reg    <= '0;
            frames_reg  <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:3])
                    REG_GAIN:  gain_reg  <= pwdata[GAIN_W-1:0];
                    REG_WLEN:  wlen_reg  <= pwdata[WLEN_W-1:0];
                    REG_WARM:  warm_reg  <= pwdata[WARM_W-1:0];
                    REG_LIMIT: limit_reg <= pwdata[RESID_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        hb_reg    <= s_host_before_ns;
                        ha_reg    <= s_host_after_ns;
                        sn_reg    <= s_sensor_ns;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    sum_reg   <= {1'b0, hb_reg} + {1'b0, ha_reg};
                    state_reg <= ST_MAG;
                end
                ST_MAG: begin
                    neg_reg   <= sum_reg < {sn_reg, 1'b0};
                    mag_reg   <= (sum_reg < {sn_reg, 1'b0}) ? {sn_reg, 1'b0} - sum_reg
                                                            : sum_reg - {sn_reg, 1'b0};
                    state_reg <= ST_SAMP;
                end
                ST_SAMP: begin
                    if (!neg_reg) begin
                        sample_reg <= (mag_reg > POS_LIM) ? SAT_POS : (mag_reg << SH);
                    end else begin
                        sample_reg <= (mag_reg >= NEG_LIM) ? SAT_NEG : 64'd0 - (mag_reg << SH);
                    end
                    state_reg <= ST_DIFF;
                end
                ST_DIFF, ST_RES: begin
                    dir_reg   <= $signed(sample_reg) < $signed(offs_reg);
                    diff_reg  <= ($signed(sample_reg) < $signed(offs_reg)) ? offs_reg - sample_reg
                                                                          : sample_reg - offs_reg;
                    state_reg <= (state_reg == ST_DIFF) ? ST_MLO : ST_WR;
                end
                ST_MLO: begin
                    prod_lo_reg <= 49'(diff_reg[31:0] * gain_eff);
                    state_reg   <= ST_MHI;
                end
                ST_MHI: begin
                    prod_hi_reg <= 49'(diff_reg[63:32] * gain_eff);
                    state_reg   <= ST_STEP;
                end
                ST_STEP: begin
                    step_reg  <= (64'(prod_hi_reg) << 16) + 64'((prod_lo_reg + 49'd32768) >> 16);
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    offs_reg  <= dir_reg ? offs_reg - step_reg : offs_reg + step_reg;
                    state_reg <= ST_RES;
                end
                ST_WR: begin
                    head_reg <= (head_reg == AW'(WINDOW_MAX - 1)) ? '0 : head_reg + AW'(1);
                    if (fill_reg < CW'(WINDOW_MAX)) begin
                        fill_reg <= fill_reg + CW'(1);
                    end
                    if (frames_reg != FRAMES_MAX) begin
                        frames_reg <= frames_reg + WARM_W'(1);
                    end
                    state_reg <= ST_MAP;
                end
                ST_MAP: begin
                    if (host_sum[64]) begin
                        host_reg <= '0;
                    end else if (host_sum[63]) begin
                        host_reg <= SAT_POS[TIME_W-1:0];
                    end else begin
                        host_reg <= host_sum[TIME_W-1:0];
                    end
                    if (oi[63:47] == '0 || oi[63:47] == '1) begin
                        ofs_reg <= oi[OFS_W-1:0];
                    end else if (oi[63]) begin
                        ofs_reg <= {1'b1, {(OFS_W-1){1'b0}}};
                    end else begin
                        ofs_reg <= {1'b0, {(OFS_W-1){1'b1}}};
                    end
                    n_reg    <= n_next;
                    i_reg    <= '0;
                    pass_reg <= 1'b0;
                    dev_reg  <= '0;
                    dval_reg <= 1'b0;
                    state_reg <= (frames_reg >= warm_reg) ? ST_CRD : ST_FIN;
                end
                ST_CRD: begin
                    state_reg <= ST_CLD;
                end
                ST_CLD: begin
                    cand_reg  <= rd_val;
                    j_reg     <= '0;
                    lt_reg    <= '0;
                    le_reg    <= '0;
                    state_reg <= ST_SWP;
                end
                ST_SWP: begin
                    lt_reg <= lt_next;
                    le_reg <= le_next;
                    j_reg  <= j_inc;
                    if (j_inc == n_reg) begin
                        if (lt_next <= k_val && k_val < le_next) begin
                            if (!pass_reg) begin
                                med_reg   <= cand_reg;
                                pass_reg  <= 1'b1;
                                i_reg     <= '0;
                                state_reg <= ST_CRD;
                            end else begin
                                dev_reg   <= cand_reg;
                                dval_reg  <= 1'b1;
                                flag_reg  <= cand_reg <= limit_reg;
                                state_reg <= ST_FIN;
                            end
                        end else begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= ST_CRD;
                        end
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        out_host_reg  <= host_reg;
                        out_ofs_reg   <= ofs_reg;
                        out_ready_reg <= flag_reg;
                        out_dev_reg   <= dev_reg;
                        out_dval_reg  <= dval_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: sv/comt_checker.sv
`include "clock_offset_mad_tracker_unit_macros.svh"

module comt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [47:0] m_offset_int_ns,
    input logic [39:0] m_deviation_ns,
    input logic        m_deviation_valid
);

    `COMT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "Result beat dropped before it was taken.")
    `COMT_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_offset_int_ns), "Result beat changed while stalled.")
    `COMT_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "Input taken again while a beat is in progress.")
    `COMT_ASSERT_SAME(a_dev_zero, aclk, aresetn, m_valid && !m_deviation_valid, m_deviation_ns == 40'd0, "Deviation nonzero without a valid flag.")

endmodule

bind clock_offset_mad_tracker_unit comt_checker u_comt_checker (.*);

// File: tb/tb_clock_offset_mad_tracker_unit.sv
`timescale 1ns / 100ps

module tb_clock_offset_mad_tracker_unit;
    import comt_pkg::*;

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX63  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          WATCHDOG_LIMIT = 40000;
    localparam int          TRACK_DEPTH = 1024;

    typedef struct packed {
        logic [62:0] hb;
        logic [62:0] ha;
        logic [62:0] sn;
    } frame_t;

    typedef struct packed {
        logic [62:0] host;
        logic [47:0] ofs;
        logic        rdy;
        logic [39:0] dev;
        logic        dvalid;
    } track_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [62:0] s_host_before_ns = '0;
    logic [62:0] s_host_after_ns = '0;
    logic [62:0] s_sensor_ns = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [62:0] m_host_time_ns;
    logic signed [47:0] m_offset_int_ns;
    logic        m_is_ready;
    logic [39:0] m_deviation_ns;
    logic        m_deviation_valid;

    clock_offset_mad_tracker_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_host_before_ns(s_host_before_ns), .s_host_after_ns(s_host_after_ns),
        .s_sensor_ns(s_sensor_ns),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_host_time_ns(m_host_time_ns), .m_offset_int_ns(m_offset_int_ns),
        .m_is_ready(m_is_ready), .m_deviation_ns(m_deviation_ns),
        .m_deviation_valid(m_deviation_valid)
    );

    always #10 aclk = ~aclk;

    logic [63:0] cfg_gain, cfg_wlen, cfg_warm, cfg_limit;
    logic [63:0] ofs_state;
    logic [39:0] resid_ring [32];
    int          ring_fill, ring_head, frames_seen;
    logic        ready_state;

    frame_t  pend_mem [TRACK_DEPTH];
    track_t  exp_mem [TRACK_DEPTH];
    int      pend_wr = 0;
    int      pend_rd = 0;
    int      exp_wr = 0;
    int      exp_rd = 0;
    int      fail_count = 0;
    int      idle_pct = 23;
    int      quiet_cycles = 0;
    logic [63:0] phase_ofs;
    int      phase_jitter;

    function automatic logic s_lt(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [63:0] gain_mul(input logic [63:0] mag, input logic [63:0] g);
        logic [63:0] hi, lo;
        hi = (mag >> 32) * g;
        lo = (mag & 64'hFFFF_FFFF) * g;
        return (hi << 16) + ((lo + 64'd32768) >> 16);
    endfunction

    function automatic logic [63:0] upper_mid(input logic [31:0][63:0] v, input int n);
        int lt, le;
        for (int i = 0; i < n; i++) begin
            lt = 0;
            le = 0;
            for (int j = 0; j < n; j++) begin
                if (v[j] < v[i]) lt++;
                if (v[j] <= v[i]) le++;
            end
            if (lt <= n / 2 && n / 2 < le) return v[i];
        end
        return 64'd0;
    endfunction

    function automatic track_t track_offset(input frame_t f);
        logic [63:0] sum, twos, mag, sample, b, g, res, med, dev, oi, host, m, q;
        logic [31:0][63:0] win;
        int wl, n;
        track_t r;
        sum = {1'b0, f.hb} + {1'b0, f.ha};
        twos = {f.sn, 1'b0};
        if (sum >= twos) begin
            mag = sum - twos;
            sample = (mag > (MAX63 >> 15)) ? MAX63 : (mag << 15);
        end else begin
            mag = twos - sum;
            sample = (mag >= (64'd1 << 48)) ? SIGN64 : (64'd0 - (mag << 15));
        end
        g = (cfg_gain > 64'd65536) ? 64'd65536 : cfg_gain;
        b = ofs_state;
        if (s_lt(sample, b)) b = b - gain_mul(b - sample, g);
        else b = b + gain_mul(sample - b, g);
        ofs_state = b;
        mag = s_lt(sample, b) ? b - sample : sample - b;
        res = (mag >> 16) + ((mag >> 15) & 64'd1);
        if (res > 64'hFF_FFFF_FFFF) res = 64'hFF_FFFF_FFFF;
        resid_ring[ring_head] = res[39:0];
        ring_head = (ring_head + 1) % 32;
        if (ring_fill < 32) ring_fill++;
        if (frames_seen < 65535) frames_seen++;
        dev = 64'd0;
        r.dvalid = 1'b0;
        if (frames_seen >= int'(cfg_warm)) begin
            wl = int'(cfg_wlen);
            if (wl == 0) wl = 1;
            if (wl > 32) wl = 32;
            n = (ring_fill < wl) ? ring_fill : wl;
            win = '0;
            for (int i = 0; i < n; i++) win[i] = 64'(resid_ring[(ring_head + 63 - i) % 32]);
            med = upper_mid(win, n);
            for (int i = 0; i < n; i++) win[i] = (win[i] >= med) ? win[i] - med : med - win[i];
            dev = upper_mid(win, n);
            r.dvalid = 1'b1;
            ready_state = (dev <= cfg_limit);
        end
        if (b[63]) begin
            m = 64'd0 - b;
            q = (m >> 16) + ((m[15:0] != 0) ? 64'd1 : 64'd0);
            oi = 64'd0 - q;
        end else begin
            oi = b >> 16;
        end
        if (oi[63]) begin
            m = 64'd0 - oi;
            host = ({1'b0, f.sn} >= m) ? {1'b0, f.sn} - m : 64'd0;
        end else begin
            host = {1'b0, f.sn} + oi;
            if (host > MAX63) host = MAX63;
        end
        if (s_lt(oi, 64'd0 - (64'd1 << 47))) oi = 64'd0 - (64'd1 << 47);
        else if (s_lt((64'd1 << 47) - 1, oi)) oi = (64'd1 << 47) - 1;
        r.host = host[62:0];
        r.ofs = oi[47:0];
        r.rdy = ready_state;
        r.dev = dev[39:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                exp_mem[exp_wr] = track_offset('{s_host_before_ns, s_host_after_ns,
                                                 s_sensor_ns});
                exp_wr++;
            end
            if (!s_valid || s_ready) begin
                if (pend_wr != pend_rd && $urandom_range(99) >= idle_pct) begin
                    s_host_before_ns <= pend_mem[pend_rd].hb;
                    s_host_after_ns <= pend_mem[pend_rd].ha;
                    s_sensor_ns <= pend_mem[pend_rd].sn;
                    pend_rd++;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        track_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
            if (m_valid && m_ready) begin
                if (exp_wr == exp_rd) begin
                    $error("result beat with no expectation");
                    fail_count++;
                end else begin
                    e = exp_mem[exp_rd];
                    exp_rd++;
                    if (m_host_time_ns !== e.host) begin
                        $error("host_time_ns exp %0d got %0d", e.host, m_host_time_ns);
                        fail_count++;
                    end
                    if (m_offset_int_ns !== e.ofs) begin
                        $error("offset_int_ns exp %0d got %0d", $signed(e.ofs),
                               m_offset_int_ns);
                        fail_count++;
                    end
                    if (m_is_ready !== e.rdy) begin
                        $error("is_ready exp %0d got %0d", e.rdy, m_is_ready);
                        fail_count++;
                    end
                    if (m_deviation_ns !== e.dev) begin
                        $error("deviation_ns exp %0d got %0d", e.dev, m_deviation_ns);
                        fail_count++;
                    end
                    if (m_deviation_valid !== e.dvalid) begin
                        $error("deviation_valid exp %0d got %0d", e.dvalid, m_deviation_valid);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)
            || (pend_wr == pend_rd && exp_wr == exp_rd)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_clock_offset_mad_tracker_unit failed");
                $finish;
            end
        end
    end

    task automatic add_frame(input frame_t f);
        pend_mem[pend_wr] = f;
        pend_wr++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GAIN:  cfg_gain = value & 64'h1FFFF;
            REG_WLEN:  cfg_wlen = value & 64'h3F;
            REG_WARM:  cfg_warm = value & 64'hFFFF;
            default:   cfg_limit = value & 64'hFF_FFFF_FFFF;
        endcase
    endtask

    task automatic set_config(input logic [63:0] gain, input logic [63:0] wlen,
                              input logic [63:0] warm, input logic [63:0] limit);
        write_reg(REG_GAIN, gain);
        write_reg(REG_WLEN, wlen);
        write_reg(REG_WARM, warm);
        write_reg(REG_LIMIT, limit);
    endtask

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    task automatic queue_random(input int count);
        frame_t f;
        logic [62:0] base;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 20) begin
                f.hb = rand63();
                f.ha = rand63();
                f.sn = rand63();
            end else begin
                base = rand63() >> $urandom_range(0, 8);
                f.hb = base;
                f.ha = base + 63'($urandom_range(0, 5000));
                f.sn = base - phase_ofs[62:0] + 63'($urandom_range(0, phase_jitter));
            end
            add_frame(f);
        end
    endtask

    task automatic drain();
        while (pend_wr != pend_rd || exp_wr != exp_rd || s_valid)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    initial begin
        cfg_gain = 64'(GAIN_RESET);
        cfg_wlen = 64'(WLEN_RESET);
        cfg_warm = 64'(WARM_RESET);
        cfg_limit = 64'(LIMIT_RESET);
        ofs_state = '0;
        ring_fill = 0;
        ring_head = 0;
        frames_seen = 0;
        ready_state = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_frame('{63'd0, 63'd0, 63'd0});
        add_frame('{MAX63[62:0], MAX63[62:0], MAX63[62:0]});
        add_frame('{MAX63[62:0], MAX63[62:0], 63'd0});
        add_frame('{63'd0, 63'd0, MAX63[62:0]});
        add_frame('{63'd0, MAX63[62:0], 63'd5});
        add_frame('{{32{2'b01}}, {32{2'b10}}, {32{2'b01}}});
        add_frame('{{32{2'b10}}, {32{2'b01}}, {32{2'b10}}});
        add_frame('{63'd1000, 63'd1002, 63'd5000});
        add_frame('{63'd5000, 63'd5001, 63'd100});
        phase_ofs = 64'd123456789;
        phase_jitter = 200;
        queue_random(11);
        drain();

        set_config(64'h1FFFF, 64'd0, 64'd0, 64'd0);
        queue_random(100);
        drain();

        phase_ofs = 64'hFFFF_FFFF_FF00_0000;
        phase_jitter = 100000;
        set_config(64'd0, 64'd1, 64'd65535, 64'hFF_FFFF_FFFF);
        queue_random(100);
        drain();

        phase_ofs = 64'd42;
        phase_jitter = 3000;
        set_config(64'd65536, 64'd32, 64'd5, 64'd1000);
        queue_random(60);
        drain();

        set_config(64'($urandom_range(1, 65535)), 64'd63, 64'd1, 64'd400);
        queue_random(40);
        drain();

        idle_pct = 0;
        phase_jitter = 1000;
        set_config(64'd3000, 64'd7, 64'd10, 64'd50000);
        queue_random(250);
        drain();

        idle_pct = 23;
        phase_ofs = 64'd0 - 64'd987654;
        phase_jitter = 800;
        set_config(64'd20000, 64'd12, 64'd3, 64'd200);
        queue_random(230);
        drain();
        repeat (2300) @(posedge aclk);

        if (fail_count == 0 && exp_wr == exp_rd) begin
            $display("tb_clock_offset_mad_tracker_unit passed");
        end else begin
            $display("tb_clock_offset_mad_tracker_unit failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/comt_pkg.sv
sv/comt_ram.sv
sv/clock_offset_mad_tracker_unit.sv
sv/comt_checker.sv
tb/tb_clock_offset_mad_tracker_unit.sv
